[src/plob_pkg.sv]
//==============================================================================
// plob_pkg
// Shared types, constants and command codes for the price-level order book.
//==============================================================================
`default_nettype none

package plob_pkg;

    localparam int DEF_NUM_LEVELS = 16;
    localparam int DEF_PRICE_BITS = 32;
    localparam int QTY_W          = 32;
    localparam int VOL_W          = 36;
    localparam int DEPTH_W        = 5;
    localparam int OUT_PRICE_W    = 32;
    localparam int SPREAD_W       = 33;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_MODIFY = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;
    localparam logic [1:0] CMD_TRADE  = 2'd3;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
        logic sum_step;
        logic sum_clear;
        logic finish;
    } plob_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sum_done;
    } plob_status_t;

endpackage

`default_nettype wire

[src/plob_if.sv]
//==============================================================================
// plob_event_if / plob_result_if / plob_cfg_if
// Valid-ready channels for events, results and the depth register.
//==============================================================================
`default_nettype none

interface plob_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic        side;
    logic [31:0] price_ticks;
    logic [31:0] quantity;
    modport source (output valid, cmd, side, price_ticks, quantity, input ready);
    modport sink   (input valid, cmd, side, price_ticks, quantity, output ready);
endinterface

interface plob_result_if;
    logic               valid;
    logic               ready;
    logic [31:0]        best_bid_price;
    logic               best_bid_valid;
    logic [31:0]        best_ask_price;
    logic               best_ask_valid;
    logic signed [32:0] spread_ticks;
    logic [35:0]        bid_volume_total;
    logic [35:0]        ask_volume_total;
    logic [35:0]        bid_volume_depth;
    logic [35:0]        ask_volume_depth;
    logic               add_dropped;
    modport source (output valid, best_bid_price, best_bid_valid, best_ask_price,
                    best_ask_valid, spread_ticks, bid_volume_total, ask_volume_total,
                    bid_volume_depth, ask_volume_depth, add_dropped, input ready);
    modport sink   (input valid, best_bid_price, best_bid_valid, best_ask_price,
                    best_ask_valid, spread_ticks, bid_volume_total, ask_volume_total,
                    bid_volume_depth, ask_volume_depth, add_dropped, output ready);
endinterface

interface plob_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] depth_levels;
    modport source (output valid, depth_levels, input ready);
    modport sink   (input valid, depth_levels, output ready);
endinterface

`default_nettype wire

[src/price_level_order_book_core.sv]
//==============================================================================
// price_level_order_book_core
// Two-sided price-level book with per-event top-of-book and volume report.
//==============================================================================
// Each event is first captured, then the book is updated with a parallel
// compare and shift over all levels, then the volume sweep visits the levels
// in turn with a total and a depth accumulator per side, and last the result
// register is loaded once it is empty. A new event is accepted once the
// previous one is fully processed and its result register is free or being
// drained. The depth register may be written at any cycle while no event is
// in flight.
`default_nettype none

module price_level_order_book_core
    import plob_pkg::*;
#(
    parameter int NUM_LEVELS = DEF_NUM_LEVELS,
    parameter int PRICE_BITS = DEF_PRICE_BITS
)
(
    input wire logic     clk,
    input wire logic     rst_n,
    plob_event_if.sink   events,
    plob_result_if.source results,
    plob_cfg_if.sink     cfg
);

    plob_cmd_t    cmd;
    plob_status_t status;

    assign cfg.ready = 1'b1;

    plob_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (events.valid),
        .in_ready  (events.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd),
        .status    (status)
    );

    plob_datapath #(
        .NUM_LEVELS (NUM_LEVELS),
        .PRICE_BITS (PRICE_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .ev_cmd           (events.cmd),
        .ev_side          (events.side),
        .ev_price         (events.price_ticks),
        .ev_qty           (events.quantity),
        .cfg_we           (cfg.valid),
        .cfg_depth        (cfg.depth_levels),
        .best_bid_price   (results.best_bid_price),
        .best_bid_valid   (results.best_bid_valid),
        .best_ask_price   (results.best_ask_price),
        .best_ask_valid   (results.best_ask_valid),
        .spread_ticks     (results.spread_ticks),
        .bid_volume_total (results.bid_volume_total),
        .ask_volume_total (results.ask_volume_total),
        .bid_volume_depth (results.bid_volume_depth),
        .ask_volume_depth (results.ask_volume_depth),
        .add_dropped      (results.add_dropped)
    );

endmodule

`default_nettype wire

[src/plob_ctrl.sv]
//==============================================================================
// plob_ctrl
// Sequencer: capture event, update book, sweep levels for volume sums, present.
//==============================================================================
`default_nettype none

module plob_ctrl
    import plob_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  wire logic   out_ready,
    output plob_cmd_t   cmd,
    input  plob_status_t status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // An event is taken once the previous result register is free or draining.
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.update    = 1'b1;
                cmd.sum_clear = 1'b1;
                state_next    = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (status.sum_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result is loaded only into an empty output register.
    a_finish_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !out_valid_reg) else $error("result overwritten");
    // A captured event always moves on to the update state.
    a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_UPD) else $error("capture sequence");
    // The sweep ends before the result is presented.
    a_sum_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM && status.sum_done) |=> state_reg == ST_OUT)
        else $error("sweep sequence");

endmodule

`default_nettype wire

[src/plob_datapath.sv]
//==============================================================================
// plob_datapath
// Level arrays for both sides, parallel match and shift, volume sweep.
//==============================================================================
`default_nettype none

module plob_datapath
    import plob_pkg::*;
#(
    parameter int NUM_LEVELS = DEF_NUM_LEVELS,
    parameter int PRICE_BITS = DEF_PRICE_BITS
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  plob_cmd_t          cmd,
    output plob_status_t       status,
    input  wire logic [1:0]    ev_cmd,
    input  wire logic          ev_side,
    input  wire logic [31:0]   ev_price,
    input  wire logic [31:0]   ev_qty,
    input  wire logic          cfg_we,
    input  wire logic [DEPTH_W-1:0] cfg_depth,
    output logic [31:0]        best_bid_price,
    output logic               best_bid_valid,
    output logic [31:0]        best_ask_price,
    output logic               best_ask_valid,
    output logic signed [32:0] spread_ticks,
    output logic [VOL_W-1:0]   bid_volume_total,
    output logic [VOL_W-1:0]   ask_volume_total,
    output logic [VOL_W-1:0]   bid_volume_depth,
    output logic [VOL_W-1:0]   ask_volume_depth,
    output logic               add_dropped
);

    localparam int IDX_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int CNT_W = $clog2(NUM_LEVELS + 1);
    localparam int PW    = (PRICE_BITS < 32) ? PRICE_BITS : 32;

    logic [PRICE_BITS-1:0] bpr_reg [2][NUM_LEVELS];
    logic [QTY_W-1:0]      qty_reg [2][NUM_LEVELS];
    logic [NUM_LEVELS-1:0] act_reg [2];

    logic [1:0]            ecmd_reg;
    logic                  eside_reg;
    logic [PRICE_BITS-1:0] eprice_reg;
    logic [QTY_W-1:0]      eqty_reg;
    logic [DEPTH_W-1:0]    depth_reg;

    logic [CNT_W-1:0]      sidx_reg;
    logic [VOL_W-1:0]      tot_reg [2];
    logic [VOL_W-1:0]      dep_reg [2];
    logic                  drop_reg;

    logic [PRICE_BITS-1:0] ext_price;
    always_comb
    begin
        ext_price = '0;
        ext_price[PW-1:0] = ev_price[PW-1:0];
    end

    // Parallel compare of the event price against every level of the chosen side.
    logic [NUM_LEVELS-1:0] hit;
    logic [NUM_LEVELS-1:0] before_new;
    logic                  found;
    logic [IDX_W-1:0]      hit_idx;
    logic [QTY_W:0]        add_sum;
    logic [QTY_W-1:0]      hit_qty;

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            hit[i] = act_reg[eside_reg][i] && (bpr_reg[eside_reg][i] == eprice_reg);
            before_new[i] = act_reg[eside_reg][i] &&
                (eside_reg ? (bpr_reg[eside_reg][i] < eprice_reg)
                           : (bpr_reg[eside_reg][i] > eprice_reg));
        end
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
        found   = |hit;
        hit_qty = qty_reg[eside_reg][hit_idx];
        add_sum = {1'b0, hit_qty} + {1'b0, eqty_reg};
    end

    // Book update, one event per update command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg[0] <= '0;
            act_reg[1] <= '0;
            depth_reg  <= DEPTH_RESET;
            drop_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                depth_reg <= cfg_depth;
            end
            if (cmd.update)
            begin
                drop_reg <= 1'b0;
                if (ecmd_reg == CMD_ADD)
                begin
                    if (found)
                    begin
                        qty_reg[eside_reg][hit_idx] <= add_sum[QTY_W] ? '1
                                                       : add_sum[QTY_W-1:0];
                    end
                    else if (act_reg[eside_reg][NUM_LEVELS-1])
                    begin
                        drop_reg <= 1'b1;
                    end
                    else
                    begin
                        // Insert: levels at or after the slot shift down by one.
                        for (int i = 0; i < NUM_LEVELS; i++)
                        begin
                            if (!before_new[i])
                            begin
                                if (i == 0 || before_new[(i > 0) ? i - 1 : 0])
                                begin
                                    bpr_reg[eside_reg][i] <= eprice_reg;
                                    qty_reg[eside_reg][i] <= eqty_reg;
                                    act_reg[eside_reg][i] <= 1'b1;
                                end
                                else
                                begin
                                    bpr_reg[eside_reg][i] <=
                                        bpr_reg[eside_reg][(i > 0) ? i - 1 : 0];
                                    qty_reg[eside_reg][i] <=
                                        qty_reg[eside_reg][(i > 0) ? i - 1 : 0];
                                    act_reg[eside_reg][i] <=
                                        act_reg[eside_reg][(i > 0) ? i - 1 : 0];
                                end
                            end
                        end
                    end
                end
                else if (ecmd_reg == CMD_MODIFY)
                begin
                    if (found)
                    begin
                        qty_reg[eside_reg][hit_idx] <= eqty_reg;
                    end
                end
                else if (found)
                begin
                    if (hit_qty > eqty_reg)
                    begin
                        qty_reg[eside_reg][hit_idx] <= hit_qty - eqty_reg;
                    end
                    else
                    begin
                        // Remove: levels after the hit move up one slot.
                        for (int i = 0; i < NUM_LEVELS; i++)
                        begin
                            if (i >= int'(hit_idx))
                            begin
                                if (i == NUM_LEVELS - 1)
                                begin
                                    bpr_reg[eside_reg][i] <= '0;
                                    qty_reg[eside_reg][i] <= '0;
                                    act_reg[eside_reg][i] <= 1'b0;
                                end
                                else
                                begin
                                    bpr_reg[eside_reg][i] <=
                                        bpr_reg[eside_reg][(i < NUM_LEVELS-1) ? i+1 : i];
                                    qty_reg[eside_reg][i] <=
                                        qty_reg[eside_reg][(i < NUM_LEVELS-1) ? i+1 : i];
                                    act_reg[eside_reg][i] <=
                                        act_reg[eside_reg][(i < NUM_LEVELS-1) ? i+1 : i];
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    // Event capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ecmd_reg   <= ev_cmd;
            eside_reg  <= ev_side;
            eprice_reg <= ext_price;
            eqty_reg   <= ev_qty;
        end
    end

    // Volume sweep: one level of each side per cycle.
    logic [IDX_W-1:0] sidx;
    logic [CNT_W-1:0] depth_eff;
    assign sidx = sidx_reg[IDX_W-1:0];
    always_comb
    begin
        if (32'(depth_reg) > 32'(NUM_LEVELS))
        begin
            depth_eff = CNT_W'(NUM_LEVELS);
        end
        else
        begin
            depth_eff = CNT_W'(depth_reg);
        end
    end
    assign status.sum_done = (sidx_reg == CNT_W'(NUM_LEVELS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.sum_clear)
        begin
            sidx_reg   <= '0;
            tot_reg[0] <= '0;
            tot_reg[1] <= '0;
            dep_reg[0] <= '0;
            dep_reg[1] <= '0;
        end
        else if (cmd.sum_step)
        begin
            sidx_reg <= sidx_reg + 1'b1;
            for (int s = 0; s < 2; s++)
            begin
                if (act_reg[s][sidx])
                begin
                    tot_reg[s] <= tot_reg[s] + VOL_W'(qty_reg[s][sidx]);
                    if (sidx_reg < depth_eff)
                    begin
                        dep_reg[s] <= dep_reg[s] + VOL_W'(qty_reg[s][sidx]);
                    end
                end
            end
        end
    end

    // Output register, loaded on finish.
    logic [31:0] bb, ba;
    always_comb
    begin
        bb = act_reg[0][0] ? 32'(bpr_reg[0][0]) : 32'd0;
        ba = act_reg[1][0] ? 32'(bpr_reg[1][0]) : 32'd0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            best_bid_price   <= bb;
            best_bid_valid   <= act_reg[0][0];
            best_ask_price   <= ba;
            best_ask_valid   <= act_reg[1][0];
            spread_ticks     <= (act_reg[0][0] && act_reg[1][0])
                                ? ({1'b0, ba} - {1'b0, bb}) : '0;
            bid_volume_total <= tot_reg[0];
            ask_volume_total <= tot_reg[1];
            bid_volume_depth <= dep_reg[0];
            ask_volume_depth <= dep_reg[1];
            add_dropped      <= drop_reg;
        end
    end

    // Active levels are packed at the low slots on both sides.
    a_packed_bid: assert property (@(posedge clk) disable iff (!rst_n)
        ((act_reg[0] & (act_reg[0] + 1'b1)) == '0)) else $error("bid gap");
    a_packed_ask: assert property (@(posedge clk) disable iff (!rst_n)
        ((act_reg[1] & (act_reg[1] + 1'b1)) == '0)) else $error("ask gap");
    // Depth volume never exceeds total volume.
    a_depth_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (bid_volume_depth <= bid_volume_total &&
                        ask_volume_depth <= ask_volume_total))
        else $error("depth above total");

endmodule

`default_nettype wire

[tb/testbench.sv]
//==============================================================================
// Order book core testbench
// Drives random and directed book events, predicts every report with an
// independent price-level book model and compares each report field by field.
//==============================================================================
`default_nettype none

module testbench;
    import plob_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVELS = DEF_NUM_LEVELS;

    typedef struct packed {
        logic [31:0]        best_bid_price;
        logic               best_bid_valid;
        logic [31:0]        best_ask_price;
        logic               best_ask_valid;
        logic signed [32:0] spread_ticks;
        logic [35:0]        bid_volume_total;
        logic [35:0]        ask_volume_total;
        logic [35:0]        bid_volume_depth;
        logic [35:0]        ask_volume_depth;
        logic               add_dropped;
    } report_t;

    // Book predictor and store of expected reports.
    class book_scoreboard;
        logic [31:0] price[2][LEVELS];
        logic [31:0] qty[2][LEVELS];
        bit          active[2][LEVELS];
        logic [4:0]  depth;
        report_t     pending[$];
        int          errors;

        function new();
            for (int s = 0; s < 2; s++)
            begin
                for (int i = 0; i < LEVELS; i++)
                begin
                    price[s][i] = '0;
                    qty[s][i] = '0;
                    active[s][i] = 0;
                end
            end
            depth = DEPTH_RESET;
            errors = 0;
        endfunction

        function int locate(int s, logic [31:0] p);
            for (int i = 0; i < LEVELS; i++)
            begin
                if (active[s][i] && price[s][i] == p)
                    return i;
            end
            return -1;
        endfunction

        // Apply one accepted event and queue the report it should produce.
        function void note_event(logic [1:0] cmd, logic side, logic [31:0] p,
                                 logic [31:0] q);
            int s;
            int idx;
            int n;
            int pos;
            int lim;
            logic [32:0] sum;
            logic [35:0] tot[2];
            logic [35:0] dep[2];
            report_t r;
            s = side;
            idx = locate(s, p);
            r = '0;
            if (cmd == CMD_ADD)
            begin
                if (idx >= 0)
                begin
                    sum = {1'b0, qty[s][idx]} + q;
                    qty[s][idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
                else
                begin
                    n = 0;
                    while (n < LEVELS && active[s][n])
                        n++;
                    if (n >= LEVELS)
                        r.add_dropped = 1'b1;
                    else
                    begin
                        pos = 0;
                        while (pos < n && (s == 0 ? price[s][pos] > p : price[s][pos] < p))
                            pos++;
                        for (int i = n; i > pos; i--)
                        begin
                            price[s][i] = price[s][i-1];
                            qty[s][i] = qty[s][i-1];
                            active[s][i] = active[s][i-1];
                        end
                        price[s][pos] = p;
                        qty[s][pos] = q;
                        active[s][pos] = 1;
                    end
                end
            end
            else if (cmd == CMD_MODIFY)
            begin
                if (idx >= 0)
                    qty[s][idx] = q;
            end
            else if (idx >= 0)
            begin
                if (qty[s][idx] > q)
                    qty[s][idx] = qty[s][idx] - q;
                else
                begin
                    for (int i = idx; i < LEVELS - 1; i++)
                    begin
                        price[s][i] = price[s][i+1];
                        qty[s][i] = qty[s][i+1];
                        active[s][i] = active[s][i+1];
                    end
                    price[s][LEVELS-1] = '0;
                    qty[s][LEVELS-1] = '0;
                    active[s][LEVELS-1] = 0;
                end
            end
            // Volume sums over both sides.
            lim = (depth > LEVELS) ? LEVELS : depth;
            for (int k = 0; k < 2; k++)
            begin
                tot[k] = '0;
                dep[k] = '0;
                for (int i = 0; i < LEVELS; i++)
                begin
                    if (active[k][i])
                    begin
                        tot[k] += qty[k][i];
                        if (i < lim)
                            dep[k] += qty[k][i];
                    end
                end
            end
            r.best_bid_valid = active[0][0];
            r.best_bid_price = active[0][0] ? price[0][0] : '0;
            r.best_ask_valid = active[1][0];
            r.best_ask_price = active[1][0] ? price[1][0] : '0;
            if (active[0][0] && active[1][0])
                r.spread_ticks = {1'b0, price[1][0]} - {1'b0, price[0][0]};
            r.bid_volume_total = tot[0];
            r.ask_volume_total = tot[1];
            r.bid_volume_depth = dep[0];
            r.ask_volume_depth = dep[1];
            pending.push_back(r);
        endfunction

        function void check_report(report_t a);
            report_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected report with no event outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.best_bid_price !== e.best_bid_price)
            begin
                $error("best_bid_price exp %0d got %0d", e.best_bid_price, a.best_bid_price);
                errors++;
            end
            if (a.best_bid_valid !== e.best_bid_valid)
            begin
                $error("best_bid_valid exp %0d got %0d", e.best_bid_valid, a.best_bid_valid);
                errors++;
            end
            if (a.best_ask_price !== e.best_ask_price)
            begin
                $error("best_ask_price exp %0d got %0d", e.best_ask_price, a.best_ask_price);
                errors++;
            end
            if (a.best_ask_valid !== e.best_ask_valid)
            begin
                $error("best_ask_valid exp %0d got %0d", e.best_ask_valid, a.best_ask_valid);
                errors++;
            end
            if (a.spread_ticks !== e.spread_ticks)
            begin
                $error("spread_ticks exp %0d got %0d", e.spread_ticks, a.spread_ticks);
                errors++;
            end
            if (a.bid_volume_total !== e.bid_volume_total)
            begin
                $error("bid_volume_total exp %0d got %0d", e.bid_volume_total,
                       a.bid_volume_total);
                errors++;
            end
            if (a.ask_volume_total !== e.ask_volume_total)
            begin
                $error("ask_volume_total exp %0d got %0d", e.ask_volume_total,
                       a.ask_volume_total);
                errors++;
            end
            if (a.bid_volume_depth !== e.bid_volume_depth)
            begin
                $error("bid_volume_depth exp %0d got %0d", e.bid_volume_depth,
                       a.bid_volume_depth);
                errors++;
            end
            if (a.ask_volume_depth !== e.ask_volume_depth)
            begin
                $error("ask_volume_depth exp %0d got %0d", e.ask_volume_depth,
                       a.ask_volume_depth);
                errors++;
            end
            if (a.add_dropped !== e.add_dropped)
            begin
                $error("add_dropped exp %0d got %0d", e.add_dropped, a.add_dropped);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   long_hold;
    bit   stall_on;

    plob_event_if  ev_if();
    plob_result_if res_if();
    plob_cfg_if    cfg_if();

    price_level_order_book_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (ev_if.sink),
        .results (res_if.source),
        .cfg     (cfg_if.sink)
    );

    book_scoreboard board;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

    // Check every report transaction at the clock edge it is taken.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            board.check_report({res_if.best_bid_price, res_if.best_bid_valid,
                                res_if.best_ask_price, res_if.best_ask_valid,
                                res_if.spread_ticks, res_if.bid_volume_total,
                                res_if.ask_volume_total, res_if.bid_volume_depth,
                                res_if.ask_volume_depth, res_if.add_dropped});
    end

    // Receiver: its own stall pattern, plus a long hold-off on request.
    initial
    begin
        int hold;
        res_if.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (long_hold)
            begin
                res_if.ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 0;
            end
            hold = $urandom_range(0, 7);
            if (stall_on && hold < 3)
                res_if.ready <= 1'b0;
            else
                res_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    int burst_left;

    // Send one event transaction, with bursts and random gaps.
    // Valid stays high between back-to-back transactions and drops only in a gap or while draining.
    task automatic send_event(logic [1:0] cmd, logic side, logic [31:0] p,
                              logic [31:0] q);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (stall_on && $urandom_range(0, 1))
            begin
                ev_if.valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
        burst_left--;
        ev_if.valid       <= 1'b1;
        ev_if.cmd         <= cmd;
        ev_if.side        <= side;
        ev_if.price_ticks <= p;
        ev_if.quantity    <= q;
        @(posedge clk);
        while (!ev_if.ready)
            @(posedge clk);
        board.note_event(cmd, side, p, q);
    endtask

    task automatic wait_drained();
        ev_if.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LEVELS + 8) @(posedge clk);
    endtask

    task automatic write_depth(logic [4:0] d);
        wait_drained();
        cfg_if.valid        <= 1'b1;
        cfg_if.depth_levels <= d;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        board.depth = d;
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random event aimed at a narrow price band so levels collide.
    task automatic random_event();
        logic [1:0]  cmd;
        logic [31:0] p;
        logic [31:0] q;
        int          s;
        s = $urandom_range(0, 1);
        cmd = $urandom_range(0, 9) < 4 ? CMD_ADD : 2'($urandom_range(1, 3));
        if ($urandom_range(0, 9) == 0)
            p = $urandom;
        else if ($urandom_range(0, 9) == 0 && board.active[s][0])
            p = board.price[s][$urandom_range(0, LEVELS - 1)];
        else
            p = 32'd1000 + $urandom_range(0, 24);
        case ($urandom_range(0, 5))
            0: q = $urandom;
            1: q = 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: q = '0;
            default: q = $urandom_range(1, 500);
        endcase
        send_event(cmd, 1'(s), p, q);
    endtask

    initial
    begin
        logic [4:0] depths[6];
        board = new();
        depths = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd5};
        rst_n = 1'b0;
        long_hold = 0;
        stall_on = 0;
        burst_left = 0;
        ev_if.valid = 1'b0;
        ev_if.cmd = CMD_ADD;
        ev_if.side = 1'b0;
        ev_if.price_ticks = '0;
        ev_if.quantity = '0;
        cfg_if.valid = 1'b0;
        cfg_if.depth_levels = DEPTH_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, saturation, zero quantity, absent levels, full side.
        send_event(CMD_ADD, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(CMD_ADD, 1'b0, 32'hFFFF_FFFF, 32'd5);
        send_event(CMD_ADD, 1'b1, 32'd0, 32'd0);
        send_event(CMD_MODIFY, 1'b1, 32'd0, 32'd7);
        send_event(CMD_MODIFY, 1'b1, 32'd9, 32'd7);
        send_event(CMD_CANCEL, 1'b0, 32'd3, 32'd1);
        send_event(CMD_TRADE, 1'b1, 32'd0, 32'd3);
        send_event(CMD_TRADE, 1'b1, 32'd0, 32'd4);
        for (int i = 0; i < LEVELS + 1; i++)
            send_event(CMD_ADD, 1'b1, 32'h5555_5555 ^ (i * 32'h0101_0101),
                       32'hAAAA_AAAA);
        send_event(CMD_CANCEL, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Random phases through several depth settings.
        stall_on = 1;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_depth(depths[ph]);
            for (int i = 0; i < 170; i++)
            begin
                if (ph == 2 && i == 50)
                    long_hold = 1;
                if (ph == 3 && i == 80)
                    wait_drained();
                random_event();
            end
        end

        wait_drained();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire

[price_level_order_book_core.f]
src/plob_pkg.sv
src/plob_if.sv
src/plob_ctrl.sv
src/plob_datapath.sv
src/price_level_order_book_core.sv
tb/testbench.sv
